FILE: hw/rtl/text_console_char_writer_core_defines.svh
// Assertion helpers for the text console checker.
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int POS_W  = 11;
  localparam int CODE_W = 9;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int BYTE_W = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
  localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_EXEC  = 7'b0001000,
    ST_COPY  = 7'b0010000,
    ST_ZERO  = 7'b0100000,
    ST_SPACE = 7'b1000000
  } tcw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // zero one cell of the reset sweep
    logic accept;  // capture the request, start the cell read
    logic rd_out;  // present the read result
    logic exec;    // move the cursor, write the character
    logic copy;    // move one cell up by a row
    logic zero;    // zero one cell of the last row
    logic space;   // write the space cell, present the put result
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last_cell;
    logic cnt_copy_end;
    logic cnt_end;
    logic scroll;
  } tcw_sts_t;

endpackage

FILE: hw/rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_cmd,
  input  tcw_pkg::tcw_sts_t  sts,
  output tcw_pkg::tcw_cmd_t  cmd,
  output logic               busy
);
  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.cnt_last_cell) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_cmd == CMD_READ) ? ST_READ : ST_EXEC;
        end
      end
      ST_READ: begin
        cmd.rd_out = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.scroll ? ST_COPY : ST_SPACE;
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.cnt_copy_end) state_nxt = ST_ZERO;
      end
      ST_ZERO: begin
        cmd.zero = 1'b1;
        if (sts.cnt_end) state_nxt = ST_SPACE;
      end
      ST_SPACE: begin
        cmd.space = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: hw/rtl/tcw_dpath.sv
module tcw_dpath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_sts_t           sts,
  input  logic [tcw_pkg::CODE_W-1:0]  in_char_code,
  input  logic [tcw_pkg::POS_W-1:0]   in_cell_index,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  output logic                        out_scrolled
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int KW    = $clog2(COLUMNS);
  localparam logic [31:0]   CELLS_U    = 32'(CELLS);
  localparam logic [CW-1:0] CNT_CELLS  = CW'(CELLS);
  localparam logic [CW-1:0] CNT_LAST   = CW'(CELLS - 1);
  localparam logic [CW-1:0] CNT_COPY   = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] CNT_COLS   = CW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ROW   = AW'(CELLS - COLUMNS);
  localparam logic [RW-1:0] ROW_END    = RW'(ROWS);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [KW-1:0] COL_LAST   = KW'(COLUMNS - 1);

  // Cell store, one write and one registered read per cycle
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [KW-1:0]     col_r, col_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic [CODE_W-1:0] code_r;
  logic              rd_ok_r;
  logic              scr_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CELL_W-1:0] out_data_r;
  logic              out_scr_r;

  logic              idx_ok;
  logic              is_nl;
  logic              is_bs;
  logic [CW-1:0]     step_pos;
  logic [RW-1:0]     step_row;
  logic [KW-1:0]     step_col;
  logic              scroll;
  logic [CW-1:0]     src;
  logic [CW-1:0]     cnt_dec;

  assign idx_ok  = (32'(in_cell_index) < CELLS_U);
  assign is_nl   = (code_r == CODE_NEWLINE);
  assign is_bs   = (code_r == CODE_BACKSPACE);
  assign src     = cnt_r + CNT_COLS;
  assign cnt_dec = cnt_r - CW'(1);

  // Cursor step for a put
  always_comb begin
    step_pos = CW'(pos_r);
    step_row = row_r;
    step_col = col_r;
    if (is_nl) begin
      step_pos = CW'(pos_r) + CNT_COLS - CW'(col_r);
      step_row = row_r + RW'(1);
      step_col = '0;
    end else if (is_bs) begin
      if (pos_r != '0) begin
        step_pos = CW'(pos_r) - CW'(1);
        if (col_r == '0) begin
          step_col = COL_LAST;
          step_row = row_r - RW'(1);
        end else begin
          step_col = col_r - KW'(1);
        end
      end
    end else begin
      step_pos = CW'(pos_r) + CW'(1);
      if (col_r == COL_LAST) begin
        step_col = '0;
        step_row = row_r + RW'(1);
      end else begin
        step_col = col_r + KW'(1);
      end
    end
  end

  assign scroll = (step_row == ROW_END);

  assign sts.cnt_last_cell = (cnt_r == CNT_LAST);
  assign sts.cnt_copy_end  = (cnt_r == CNT_COPY);
  assign sts.cnt_end       = (cnt_r == CNT_CELLS);
  assign sts.scroll        = scroll;

  // Write port
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = '0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = AW'(cnt_r);
    end else if (cmd.exec) begin
      we    = !is_nl && !is_bs;
      wdata = {attr_r, code_r[BYTE_W-1:0]};
    end else if (cmd.copy) begin
      we    = (cnt_r != '0);
      waddr = AW'(cnt_dec);
      wdata = rdata_r;
    end else if (cmd.zero) begin
      we    = 1'b1;
      waddr = AW'(cnt_dec);
    end else if (cmd.space) begin
      we    = 1'b1;
      wdata = {attr_r, CHAR_SPACE};
    end
  end

  // Read port: source row during a scroll, else the requested cell
  always_comb begin
    if (cmd.copy) begin
      raddr = (src < CNT_CELLS) ? AW'(src) : '0;
    end else begin
      raddr = idx_ok ? AW'(in_cell_index) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = sts.cnt_last_cell ? '0 : cnt_r + CW'(1);
    end else if (cmd.copy) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.zero) begin
      cnt_nxt = sts.cnt_end ? '0 : cnt_r + CW'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.exec) begin
      pos_nxt = scroll ? LAST_ROW : AW'(step_pos);
      row_nxt = scroll ? ROW_LAST : step_row;
      col_nxt = step_col;
    end
  end

  assign attr_nxt = cfg_wr_en ? cfg_wr_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= cmd.rd_out | cmd.space;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_r  <= in_char_code;
      rd_ok_r <= idx_ok;
    end
    if (cmd.exec) scr_r <= scroll;
    if (cmd.rd_out) begin
      out_pos_r  <= POS_W'(pos_r);
      out_data_r <= rd_ok_r ? rdata_r : '0;
      out_scr_r  <= 1'b0;
    end else if (cmd.space) begin
      out_pos_r  <= POS_W'(pos_r);
      out_data_r <= '0;
      out_scr_r  <= scr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scr_r;

endmodule

FILE: hw/rtl/text_console_char_writer_core.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------------------
// request   | start in, busy out        | in_cmd, in_char_code, in_cell_index
// result    | out_valid strobe, 1 cycle | out_cursor_pos, out_cell_data, out_scrolled
// config    | cfg_wr_en                 | cfg_wr_data (text attribute)
//
// From acceptance to the next request a read passes through ST_READ, a put without
// scroll through ST_EXEC and ST_SPACE; the result strobes in the cycle in which busy
// drops, which may overlap the next request. In a scrolling put the cell memory moves
// one cell per cycle through its registered read port, then zeroes the last row one
// cell per cycle. After reset, busy stays high while the store is cleared.
// Results cannot be stalled; each is shown for exactly one cycle.
module text_console_char_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [tcw_pkg::CODE_W-1:0]  in_char_code,
  input  logic [tcw_pkg::POS_W-1:0]   in_cell_index,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  output logic                        out_valid,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  output logic                        out_scrolled
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

endmodule

FILE: hw/rtl/tcw_checker.sv
`include "text_console_char_writer_core_defines.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  input logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  input logic                        out_scrolled
);
  import tcw_pkg::*;

  localparam int               CELLS      = ROWS * COLUMNS;
  localparam logic [31:0]      CELLS_U    = 32'(CELLS);
  localparam logic [31:0]      POS_SPAN   = 32'(2 ** POS_W);
  localparam logic [POS_W-1:0] SCROLL_POS = POS_W'(CELLS - COLUMNS);

  // An accepted request keeps the block busy in the next cycle.
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

  // Every request passes through a busy state, so strobes never touch.
  `TCW_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "result strobes back to back")

  // Only puts scroll, and puts return no cell data.
  `TCW_ASSERT_SAME(a_scroll_data, out_valid && out_scrolled, out_cell_data == '0,
                   "scrolled result carries cell data")

  // After a scroll the cursor sits at the start of the last row.
  `TCW_ASSERT_SAME(a_scroll_pos, out_valid && out_scrolled, out_cursor_pos == SCROLL_POS,
                   "cursor not on last row after scroll")

  // The cursor stays inside the screen.
  `TCW_ASSERT_SAME(a_pos_range, out_valid,
                   (CELLS_U > POS_SPAN) || (32'(out_cursor_pos) < CELLS_U),
                   "cursor outside the screen")

endmodule

bind text_console_char_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_cursor_pos (out_cursor_pos),
  .out_cell_data  (out_cell_data),
  .out_scrolled   (out_scrolled)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASE_ITEMS = 450;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [CELL_W-1:0] data;
    logic              scrolled;
  } console_result_t;

  typedef struct packed {
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  idx;
    logic [7:0]        reps;
    logic              typed;
    logic [POS_W-1:0]  want_cursor;
    logic [CELL_W-1:0] want_data;
    logic              want_scrolled;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 22;

  // Rows with typed set carry a hand-written expectation; the rest use the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ, 9'd0,           11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd2047, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd1999, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  CODE_BACKSPACE, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd0,    8'd1,  1'b1, 11'd0,    16'h0720, 1'b0},
    '{CMD_PUT,  9'd65,          11'd2047, 8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  9'd255,         11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  9'd266,         11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  9'd511,         11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  9'd0,           11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  9'd128,         11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd2,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd5,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  CODE_NEWLINE,   11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  CODE_BACKSPACE, 11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  CODE_NEWLINE,   11'd0,    8'd24, 1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_PUT,  CODE_NEWLINE,   11'd0,    8'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
    '{CMD_READ, 9'd0,           11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd1919, 8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd1920, 8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{CMD_READ, 9'd0,           11'd1999, 8'd1,  1'b1, 11'd1920, 16'h0000, 1'b0},
    '{CMD_PUT,  CODE_BACKSPACE, 11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_cmd = 1'b0;
  logic [CODE_W-1:0]  in_char_code = '0;
  logic [POS_W-1:0]   in_cell_index = '0;
  logic               cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0]  cfg_wr_data = '0;
  logic               out_valid;
  logic [POS_W-1:0]   out_cursor_pos;
  logic [CELL_W-1:0]  out_cell_data;
  logic               out_scrolled;

  text_console_char_writer_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

  // Shadow copy of the console state
  logic [CELL_W-1:0] screen_shadow [CELLS];
  logic [POS_W-1:0]  cursor_shadow;
  logic [ATTR_W-1:0] attr_shadow;

  console_result_t pending_results [$];
  int              idle_pct;
  int              requests_sent;
  int              reads_sent;
  int              scrolls_predicted;
  int              mismatch_count = 0;
  int              cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic console_result_t predict_console(input logic cmd,
                                                      input logic [CODE_W-1:0] code,
                                                      input logic [POS_W-1:0] idx);
    console_result_t r;
    int unsigned     pos;
    r = '0;
    if (cmd == CMD_READ) begin
      if (idx < CELLS) r.data = screen_shadow[idx];
    end else begin
      pos = 32'(cursor_shadow);
      if (code == CODE_NEWLINE) begin
        pos = pos + COLS - pos % COLS;
      end else if (code == CODE_BACKSPACE) begin
        if (pos > 0) pos--;
      end else begin
        screen_shadow[pos] = {attr_shadow, code[BYTE_W-1:0]};
        pos++;
      end
      if (pos >= CELLS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
        pos -= COLS;
        for (int i = int'(pos); i < CELLS; i++) screen_shadow[i] = '0;
        r.scrolled = 1'b1;
      end
      cursor_shadow = POS_W'(pos);
      screen_shadow[pos] = {attr_shadow, CHAR_SPACE};
    end
    r.cursor = cursor_shadow;
    return r;
  endfunction

  task automatic send_request(input logic cmd, input logic [CODE_W-1:0] code,
                              input logic [POS_W-1:0] idx, input logic typed,
                              input console_result_t want);
    console_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    r = predict_console(cmd, code, idx);
    pending_results.push_back(typed ? want : r);
    requests_sent++;
    if (cmd == CMD_READ) reads_sent++;
    if (r.scrolled) scrolls_predicted++;
  endtask

  task automatic send_random_request();
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  idx;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    cmd  = CMD_PUT;
    code = '0;
    idx  = POS_W'($urandom_range(0, 2047));
    if (pick < 30) begin
      cmd = CMD_READ;
      // aim half the reads at cells just written
      if ($urandom_range(0, 1) && cursor_shadow >= 3)
        idx = POS_W'(cursor_shadow - $urandom_range(0, 3));
    end else if (pick < 40) begin
      code = CODE_NEWLINE;
    end else if (pick < 48) begin
      code = CODE_BACKSPACE;
    end else if (pick < 52) begin
      code = CODE_W'($urandom_range(257, 511));
    end else begin
      code = CODE_W'($urandom_range(0, 255));
    end
    send_request(cmd, code, idx, 1'b0, '0);
  endtask

  // Hold off new requests until every result is back and the block is quiet.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    attr_shadow = value;
  endtask

  task automatic run_random_phase(input int pct, input int count);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      send_random_request();
      if ($urandom_range(0, 99) == 0) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk) begin : result_monitor
    console_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0t] unexpected result: cursor %0d data %h scrolled %b", $realtime,
                   out_cursor_pos, out_cell_data, out_scrolled);
      end else begin
        want = pending_results.pop_front();
        if (out_cursor_pos !== want.cursor || out_cell_data !== want.data ||
            out_scrolled !== want.scrolled) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            if (out_cursor_pos !== want.cursor)
              $display("[%0t] cursor_pos: expected %0d, got %0d", $realtime,
                       want.cursor, out_cursor_pos);
            if (out_cell_data !== want.data)
              $display("[%0t] cell_data: expected %h, got %h", $realtime,
                       want.data, out_cell_data);
            if (out_scrolled !== want.scrolled)
              $display("[%0t] scrolled: expected %b, got %b", $realtime,
                       want.scrolled, out_scrolled);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    console_result_t want;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = '0;
    cursor_shadow     = '0;
    attr_shadow       = ATTR_RESET;
    idle_pct          = 15;
    requests_sent     = 0;
    reads_sent        = 0;
    scrolls_predicted = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      want = {directed_rows[k].want_cursor, directed_rows[k].want_data,
              directed_rows[k].want_scrolled};
      for (int n = 0; n < directed_rows[k].reps; n++)
        send_request(directed_rows[k].cmd, directed_rows[k].code, directed_rows[k].idx,
                     directed_rows[k].typed, want);
    end
    drain_results();

    set_text_attribute(8'hFF);
    run_random_phase(15, PHASE_ITEMS);
    set_text_attribute(8'h00);
    run_random_phase(84, PHASE_ITEMS);
    set_text_attribute(ATTR_W'($urandom_range(1, 254)));
    run_random_phase(0, PHASE_ITEMS);

    $display("Sent %0d requests (%0d reads, %0d scrolling puts) over four attribute settings,",
             requests_sent, reads_sent, scrolls_predicted);
    $display("with sender gaps of 15%%, 84%% and none; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
